[hw/rtl/rvexe_pkg.sv]
package rvexe_pkg;

  // Operation class of an issued micro-op.
  typedef enum logic [3:0] {
    MODE_LUI    = 4'd0,
    MODE_AUIPC  = 4'd1,
    MODE_JAL    = 4'd2,
    MODE_JALR   = 4'd3,
    MODE_BRANCH = 4'd4,
    MODE_LOAD   = 4'd5,
    MODE_STORE  = 4'd6,
    MODE_OPIMM  = 4'd7,
    MODE_OP     = 4'd8
  } mode_t;

  // Branch conditions, by funct3.
  localparam logic [2:0] BR_EQ  = 3'd0;
  localparam logic [2:0] BR_NE  = 3'd1;
  localparam logic [2:0] BR_LT  = 3'd4;
  localparam logic [2:0] BR_GE  = 3'd5;
  localparam logic [2:0] BR_LTU = 3'd6;
  localparam logic [2:0] BR_GEU = 3'd7;

  // Arithmetic operations, by funct3.
  localparam logic [2:0] ALU_ADD  = 3'd0;
  localparam logic [2:0] ALU_SLL  = 3'd1;
  localparam logic [2:0] ALU_SLT  = 3'd2;
  localparam logic [2:0] ALU_SLTU = 3'd3;
  localparam logic [2:0] ALU_XOR  = 3'd4;
  localparam logic [2:0] ALU_SR   = 3'd5;
  localparam logic [2:0] ALU_OR   = 3'd6;
  localparam logic [2:0] ALU_AND  = 3'd7;

  // Funct7 encodings that select alternative operations.
  localparam logic [6:0] F7_BASE   = 7'h00;
  localparam logic [6:0] F7_ALT    = 7'h20;
  localparam logic [6:0] F7_MULDIV = 7'h01;

  // Memory access kinds.
  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_LOAD  = 2'd1;
  localparam logic [1:0] MEM_STORE = 2'd2;

  localparam logic [31:0] ALL_ONES = 32'hffff_ffff;
  localparam logic [31:0] PC_STEP  = 32'd4;

  // Entries in the queue between decode and execute.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Decoded micro-op as held in the queue.
  typedef struct packed {
    logic        err;
    mode_t       mode;
    logic [2:0]  f3;
    logic        alt;
    logic        muldiv;
    logic        is_div;
    logic [31:0] imm;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] pc;
    logic [31:0] guess;
    logic [5:0]  tag;
    logic [4:0]  rd;
  } uop_t;

  // One result word.
  typedef struct packed {
    logic [5:0]  tag;
    logic [4:0]  dest;
    logic        reg_write;
    logic [31:0] value;
    logic [1:0]  mem_kind;
    logic [31:0] mem_address;
    logic [31:0] store_data;
    logic        redirect_valid;
    logic [31:0] redirect_pc;
    logic        error_code;
  } res_t;

endpackage

[hw/rtl/rv32_execute_with_branch_resolve_top.sv]
// Integer execute unit with branch resolution for an RV32 core.
// An issued micro-op is taken at a rising edge where start is high and busy
// is low; its fields arrive on the in_ ports. Decode classifies the word and
// places it in a two-entry queue; execute pops a word a cycle if no divide runs.
// Each micro-op gives exactly one result word on the out_ ports, shown for
// one cycle with out_valid high. The receiver cannot stall, so a result is
// always taken in the cycle it appears.
// The result word is registered on the execute side; a signed divide first
// goes through the radix-2 restoring divider, which steps one quotient bit
// a cycle and then hands its quotient to the result register.
// Throughput: one word a cycle while no divide is running; a divide holds
// the execute side while it runs, and busy rises once the queue has filled.
// Reset clears the queue and the strobe; no result follows reset until a
// new word is taken.
module rv32_execute_with_branch_resolve_top
  import rvexe_pkg::*;
#(
  parameter int unsigned TAG_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_mode,
  input  logic [2:0]  in_funct3,
  input  logic [6:0]  in_funct7,
  input  logic [31:0] in_immediate,
  input  logic [31:0] in_source_a,
  input  logic [31:0] in_source_b,
  input  logic [31:0] in_inst_pc,
  input  logic [31:0] in_guessed_pc,
  input  logic [5:0]  in_rob_tag,
  input  logic [4:0]  in_dest_reg,
  output logic        out_valid,
  output logic [5:0]  out_tag_out,
  output logic [4:0]  out_dest_out,
  output logic        out_reg_write,
  output logic [31:0] out_result_value,
  output logic [1:0]  out_mem_kind,
  output logic [31:0] out_mem_address,
  output logic [31:0] out_store_data,
  output logic        out_redirect_valid,
  output logic [31:0] out_redirect_pc,
  output logic        out_error_code
);

  uop_t dec_uop;
  uop_t head;
  logic q_empty;
  logic q_full;
  logic q_pop;
  logic push;
  res_t res;

  assign busy = q_full;
  assign push = start && !q_full;

  rvexe_front #(
    .TAG_ENTRIES (TAG_ENTRIES)
  ) u_front (
    .mode       (in_mode),
    .funct3     (in_funct3),
    .funct7     (in_funct7),
    .immediate  (in_immediate),
    .source_a   (in_source_a),
    .source_b   (in_source_b),
    .inst_pc    (in_inst_pc),
    .guessed_pc (in_guessed_pc),
    .rob_tag    (in_rob_tag),
    .dest_reg   (in_dest_reg),
    .uop        (dec_uop)
  );

  rvexe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (dec_uop),
    .pop       (q_pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  rvexe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (q_empty),
    .pop       (q_pop),
    .res_valid (out_valid),
    .res       (res)
  );

  // Result word onto the ports.
  assign out_tag_out        = res.tag;
  assign out_dest_out       = res.dest;
  assign out_reg_write      = res.reg_write;
  assign out_result_value   = res.value;
  assign out_mem_kind       = res.mem_kind;
  assign out_mem_address    = res.mem_address;
  assign out_store_data     = res.store_data;
  assign out_redirect_valid = res.redirect_valid;
  assign out_redirect_pc    = res.redirect_pc;
  assign out_error_code     = res.error_code;

endmodule

[hw/rtl/rvexe_front.sv]
module rvexe_front
  import rvexe_pkg::*;
#(
  parameter int unsigned TAG_ENTRIES = 64
) (
  input  logic [3:0]  mode,
  input  logic [2:0]  funct3,
  input  logic [6:0]  funct7,
  input  logic [31:0] immediate,
  input  logic [31:0] source_a,
  input  logic [31:0] source_b,
  input  logic [31:0] inst_pc,
  input  logic [31:0] guessed_pc,
  input  logic [5:0]  rob_tag,
  input  logic [4:0]  dest_reg,
  output uop_t        uop
);

  logic       is_alt;
  logic       is_md;
  logic       err;
  logic [5:0] tag_fold [64];

  assign is_alt = (funct7 == F7_ALT);
  assign is_md  = (funct7 == F7_MULDIV);

  // Every tag folded onto the tag space, worked out at elaboration.
  for (genvar g = 0; g < 64; g++) begin : g_tag_fold
    assign tag_fold[g] = 6'(g % TAG_ENTRIES);
  end

  // Classify the word and flag encodings that the unit does not support.
  always_comb begin
    err = 1'b0;
    unique case (mode_t'(mode))
      MODE_LUI, MODE_AUIPC, MODE_JAL, MODE_JALR,
      MODE_LOAD, MODE_STORE, MODE_OPIMM: begin
        err = 1'b0;
      end
      MODE_BRANCH: begin
        err = (funct3 == 3'd2) || (funct3 == 3'd3);
      end
      MODE_OP: begin
        if (is_md) begin
          err = (funct3 != ALU_ADD) && (funct3 != ALU_XOR);
        end else begin
          err = (funct3 == ALU_ADD) && (funct7 != F7_BASE) && !is_alt;
        end
      end
      default: begin
        err = 1'b1;
      end
    endcase
  end

  // Pack the decoded word; the tag is folded onto the tag space.
  always_comb begin
    uop.err    = err;
    uop.mode   = mode_t'(mode);
    uop.f3     = funct3;
    uop.alt    = is_alt;
    uop.muldiv = is_md;
    uop.is_div = !err && (mode_t'(mode) == MODE_OP) && is_md && (funct3 == ALU_XOR);
    uop.imm    = immediate;
    uop.a      = source_a;
    uop.b      = source_b;
    uop.pc     = inst_pc;
    uop.guess  = guessed_pc;
    uop.tag    = tag_fold[rob_tag];
    uop.rd     = dest_reg;
  end

endmodule

[hw/rtl/rvexe_queue.sv]
module rvexe_queue
  import rvexe_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  uop_t push_data,
  input  logic pop,
  output uop_t head,
  output logic empty,
  output logic full
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  uop_t                 mem_r [QUEUE_DEPTH];
  logic [PW-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] count_r, count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH));
  assign head  = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[hw/rtl/rvexe_div.sv]
module rvexe_div
  import rvexe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        active,
  output logic        done,
  output logic [31:0] quotient
);

  logic        active_r, active_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] ay_r;
  logic        neg_r;
  logic        yzero_r;
  logic [32:0] rem_sh;
  logic [32:0] diff;
  logic        ge;

  assign active = active_r;

  // One restoring step a cycle on magnitudes.
  always_comb begin
    rem_sh   = {rem_r, quo_r[31]};
    diff     = rem_sh - {1'b0, ay_r};
    ge       = !diff[32];
    rem_nxt  = ge ? diff[31:0] : rem_sh[31:0];
    quo_nxt  = {quo_r[30:0], ge};
    done     = active_r && (cnt_r == '0);
    quotient = yzero_r ? ALL_ONES : (neg_r ? (32'd0 - quo_nxt) : quo_nxt);
    cnt_nxt  = cnt_r - 1'b1;
    active_nxt = active_r && (cnt_r != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (start) begin
      active_r <= 1'b1;
    end else begin
      active_r <= active_nxt;
    end
  end

  // Operand set-up on start, then the step registers.
  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r   <= 5'd31;
      rem_r   <= '0;
      quo_r   <= dividend[31] ? (32'd0 - dividend) : dividend;
      ay_r    <= divisor[31] ? (32'd0 - divisor) : divisor;
      neg_r   <= dividend[31] ^ divisor[31];
      yzero_r <= (divisor == '0);
    end else if (active_r) begin
      cnt_r <= cnt_nxt;
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

endmodule

[hw/rtl/rvexe_back.sv]
module rvexe_back
  import rvexe_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  uop_t head,
  input  logic empty,
  output logic pop,
  output logic res_valid,
  output res_t res
);

  logic        div_active;
  logic        div_done;
  logic [31:0] div_q;
  logic        div_start;
  logic [5:0]  div_tag_r;
  logic [4:0]  div_rd_r;
  res_t        div_res;

  logic        res_valid_r;
  res_t        res_r, res_nxt;

  logic [31:0] opb;
  logic [4:0]  shamt;
  logic [31:0] sum_ab;
  logic [31:0] pc_imm;
  logic [31:0] pc_4;
  logic [31:0] prod;
  logic        lt_s;
  logic        lt_u;
  logic        take;
  logic        jump;
  logic        writes;
  logic [31:0] next_pc;
  logic [31:0] val;
  logic [31:0] alu;

  assign pop       = !empty && !div_active;
  assign div_start = pop && head.is_div;
  assign res_valid = res_valid_r;
  assign res       = res_r;

  rvexe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (head.a),
    .divisor  (head.b),
    .active   (div_active),
    .done     (div_done),
    .quotient (div_q)
  );

  // Shared operand paths; register forms and branches compare against b.
  always_comb begin
    opb    = (head.mode == MODE_OP || head.mode == MODE_BRANCH) ? head.b : head.imm;
    shamt  = opb[4:0];
    sum_ab = head.a + opb;
    pc_imm = head.pc + head.imm;
    pc_4   = head.pc + PC_STEP;
    prod   = head.a * head.b;
    lt_s   = $signed(head.a) < $signed(opb);
    lt_u   = head.a < opb;
  end

  // Integer operations for register and immediate forms.
  always_comb begin
    case (head.f3)
      ALU_ADD: begin
        if (head.mode == MODE_OP && head.muldiv) begin
          alu = prod;
        end else if (head.mode == MODE_OP && head.alt) begin
          alu = head.a - head.b;
        end else begin
          alu = sum_ab;
        end
      end
      ALU_SLL:  alu = head.a << shamt;
      ALU_SLT:  alu = {31'd0, lt_s};
      ALU_SLTU: alu = {31'd0, lt_u};
      ALU_XOR:  alu = head.a ^ opb;
      ALU_SR: begin
        alu = head.alt ? 32'($signed(head.a) >>> shamt) : (head.a >> shamt);
      end
      ALU_OR:   alu = head.a | opb;
      default:  alu = head.a & opb;
    endcase
  end

  // Branch condition.
  always_comb begin
    unique case (head.f3)
      BR_EQ:   take = (head.a == head.b);
      BR_NE:   take = (head.a != head.b);
      BR_LT:   take = lt_s;
      BR_GE:   take = !lt_s;
      BR_LTU:  take = lt_u;
      BR_GEU:  take = !lt_u;
      default: take = 1'b0;
    endcase
  end

  // Per-class result, then masking for errors and register zero.
  always_comb begin
    writes  = 1'b0;
    jump    = 1'b0;
    next_pc = '0;
    val     = '0;
    res_nxt = '0;
    res_nxt.tag  = head.tag;
    res_nxt.dest = head.rd;
    unique case (head.mode)
      MODE_LUI: begin
        writes = 1'b1;
        val    = head.imm;
      end
      MODE_AUIPC: begin
        writes = 1'b1;
        val    = pc_imm;
      end
      MODE_JAL: begin
        writes  = 1'b1;
        val     = pc_4;
        jump    = 1'b1;
        next_pc = pc_imm;
      end
      MODE_JALR: begin
        writes  = 1'b1;
        val     = pc_4;
        jump    = 1'b1;
        next_pc = {sum_ab[31:1], 1'b0};
      end
      MODE_BRANCH: begin
        jump    = 1'b1;
        next_pc = take ? pc_imm : pc_4;
      end
      MODE_LOAD: begin
        writes               = 1'b1;
        res_nxt.mem_kind     = MEM_LOAD;
        res_nxt.mem_address  = sum_ab;
      end
      MODE_STORE: begin
        res_nxt.mem_kind     = MEM_STORE;
        res_nxt.mem_address  = sum_ab;
        res_nxt.store_data   = head.b;
      end
      MODE_OPIMM, MODE_OP: begin
        writes = 1'b1;
        val    = alu;
      end
      default: begin
        writes = 1'b0;
      end
    endcase
    if (head.err) begin
      res_nxt.mem_kind    = MEM_NONE;
      res_nxt.mem_address = '0;
      res_nxt.store_data  = '0;
      res_nxt.error_code  = 1'b1;
      writes              = 1'b0;
      jump                = 1'b0;
    end
    if (head.mode == MODE_LOAD) begin
      val = '0;
    end
    res_nxt.reg_write      = writes && (head.rd != '0);
    res_nxt.value          = res_nxt.reg_write ? val : '0;
    res_nxt.redirect_valid = jump && (next_pc != head.guess);
    res_nxt.redirect_pc    = res_nxt.redirect_valid ? next_pc : '0;
  end

  // Result word of a finished divide.
  always_comb begin
    div_res           = '0;
    div_res.tag       = div_tag_r;
    div_res.dest      = div_rd_r;
    div_res.reg_write = (div_rd_r != '0);
    div_res.value     = (div_rd_r != '0) ? div_q : '0;
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= div_done || (pop && !head.is_div);
    end
  end

  // Result word, from the divider on completion or from the combinational path.
  always_ff @(posedge clk) begin
    if (div_start) begin
      div_tag_r <= head.tag;
      div_rd_r  <= head.rd;
    end
    if (div_done) begin
      res_r <= div_res;
    end else if (pop && !head.is_div) begin
      res_r <= res_nxt;
    end
  end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps

module tb_top
  import rvexe_pkg::*;
();

  // One issued micro-op as the driver sees it.
  typedef struct {
    logic [3:0]  mode;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] imm;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] pc;
    logic [31:0] guess;
    logic [5:0]  tag;
    logic [4:0]  rd;
  } uop_word_t;

  localparam int unsigned TAG_ENTRIES_TB = 64;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [3:0]  in_mode;
  logic [2:0]  in_funct3;
  logic [6:0]  in_funct7;
  logic [31:0] in_immediate;
  logic [31:0] in_source_a;
  logic [31:0] in_source_b;
  logic [31:0] in_inst_pc;
  logic [31:0] in_guessed_pc;
  logic [5:0]  in_rob_tag;
  logic [4:0]  in_dest_reg;
  logic        out_valid;
  logic [5:0]  out_tag_out;
  logic [4:0]  out_dest_out;
  logic        out_reg_write;
  logic [31:0] out_result_value;
  logic [1:0]  out_mem_kind;
  logic [31:0] out_mem_address;
  logic [31:0] out_store_data;
  logic        out_redirect_valid;
  logic [31:0] out_redirect_pc;
  logic        out_error_code;

  uop_word_t pending_uops[$];
  res_t      expected_results[$];
  int        idle_pct;
  int        n_errors;

  rv32_execute_with_branch_resolve_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_mode           (in_mode),
    .in_funct3         (in_funct3),
    .in_funct7         (in_funct7),
    .in_immediate      (in_immediate),
    .in_source_a       (in_source_a),
    .in_source_b       (in_source_b),
    .in_inst_pc        (in_inst_pc),
    .in_guessed_pc     (in_guessed_pc),
    .in_rob_tag        (in_rob_tag),
    .in_dest_reg       (in_dest_reg),
    .out_valid         (out_valid),
    .out_tag_out       (out_tag_out),
    .out_dest_out      (out_dest_out),
    .out_reg_write     (out_reg_write),
    .out_result_value  (out_result_value),
    .out_mem_kind      (out_mem_kind),
    .out_mem_address   (out_mem_address),
    .out_store_data    (out_store_data),
    .out_redirect_valid(out_redirect_valid),
    .out_redirect_pc   (out_redirect_pc),
    .out_error_code    (out_error_code)
  );

  // Clock, 10 ns period.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Signed less-than on 32-bit words.
  function automatic bit signed_lt(logic [31:0] x, logic [31:0] y);
    return $signed(x) < $signed(y);
  endfunction

  // Signed divide with the RISC-V rules for zero and overflow.
  function automatic logic [31:0] signed_quotient(logic [31:0] x, logic [31:0] y);
    logic [31:0] mag_x;
    logic [31:0] mag_y;
    logic [31:0] q;
    if (y == '0) return ALL_ONES;
    if (x == 32'h8000_0000 && y == ALL_ONES) return x;
    mag_x = x[31] ? -x : x;
    mag_y = y[31] ? -y : y;
    q = mag_x / mag_y;
    return (x[31] ^ y[31]) ? -q : q;
  endfunction

  // Works out the single result word that a micro-op gives.
  function automatic res_t execute_uop(uop_word_t u);
    res_t        r;
    bit          writes;
    bit          err;
    bit          jump;
    bit          take;
    logic [31:0] val;
    logic [31:0] nxt;
    logic [4:0]  sh;
    r = '0;
    writes = 0;
    err = 0;
    jump = 0;
    take = 0;
    val = '0;
    nxt = '0;
    sh = u.imm[4:0];
    case (u.mode)
      MODE_LUI: begin
        writes = 1;
        val = u.imm;
      end
      MODE_AUIPC: begin
        writes = 1;
        val = u.pc + u.imm;
      end
      MODE_JAL: begin
        writes = 1;
        val = u.pc + PC_STEP;
        jump = 1;
        nxt = u.pc + u.imm;
      end
      MODE_JALR: begin
        writes = 1;
        val = u.pc + PC_STEP;
        jump = 1;
        nxt = (u.a + u.imm) & ~32'd1;
      end
      MODE_BRANCH: begin
        case (u.f3)
          BR_EQ:  take = (u.a == u.b);
          BR_NE:  take = (u.a != u.b);
          BR_LT:  take = signed_lt(u.a, u.b);
          BR_GE:  take = !signed_lt(u.a, u.b);
          BR_LTU: take = (u.a < u.b);
          BR_GEU: take = (u.a >= u.b);
          default: err = 1;
        endcase
        jump = 1;
        nxt = take ? u.pc + u.imm : u.pc + PC_STEP;
      end
      MODE_LOAD: begin
        writes = 1;
        r.mem_kind = MEM_LOAD;
        r.mem_address = u.a + u.imm;
      end
      MODE_STORE: begin
        r.mem_kind = MEM_STORE;
        r.mem_address = u.a + u.imm;
        r.store_data = u.b;
      end
      MODE_OPIMM: begin
        writes = 1;
        case (u.f3)
          ALU_ADD:  val = u.a + u.imm;
          ALU_SLL:  val = u.a << sh;
          ALU_SLT:  val = {31'd0, signed_lt(u.a, u.imm)};
          ALU_SLTU: val = {31'd0, (u.a < u.imm)};
          ALU_XOR:  val = u.a ^ u.imm;
          ALU_SR: begin
            if (u.f7 == F7_ALT) val = $signed(u.a) >>> sh;
            else val = u.a >> sh;
          end
          ALU_OR:   val = u.a | u.imm;
          default:  val = u.a & u.imm;
        endcase
      end
      MODE_OP: begin
        writes = 1;
        sh = u.b[4:0];
        if (u.f7 == F7_MULDIV && u.f3 != ALU_ADD && u.f3 != ALU_XOR) begin
          err = 1;
        end else begin
          case (u.f3)
            ALU_ADD: begin
              if (u.f7 == F7_BASE) val = u.a + u.b;
              else if (u.f7 == F7_ALT) val = u.a - u.b;
              else if (u.f7 == F7_MULDIV) val = u.a * u.b;
              else err = 1;
            end
            ALU_SLL:  val = u.a << sh;
            ALU_SLT:  val = {31'd0, signed_lt(u.a, u.b)};
            ALU_SLTU: val = {31'd0, (u.a < u.b)};
            ALU_XOR:  val = (u.f7 == F7_MULDIV) ? signed_quotient(u.a, u.b) : u.a ^ u.b;
            ALU_SR: begin
              if (u.f7 == F7_ALT) val = $signed(u.a) >>> sh;
              else val = u.a >> sh;
            end
            ALU_OR:   val = u.a | u.b;
            default:  val = u.a & u.b;
          endcase
        end
      end
      default: err = 1;
    endcase

    if (err) begin
      writes = 0;
      r.mem_kind = MEM_NONE;
      r.mem_address = '0;
      r.store_data = '0;
      jump = 0;
    end
    if (r.mem_kind == MEM_LOAD || u.rd == '0 || !writes) val = '0;
    if (u.rd == '0) writes = 0;
    jump = jump && (nxt != u.guess);

    r.tag = 6'(u.tag % TAG_ENTRIES_TB);
    r.dest = u.rd;
    r.reg_write = writes;
    r.value = val;
    r.redirect_valid = jump;
    r.redirect_pc = jump ? nxt : '0;
    r.error_code = err;
    return r;
  endfunction

  // Queues one micro-op for the driver; its expected result is worked out when the word is taken.
  task automatic push_uop(uop_word_t u);
    pending_uops.push_back(u);
  endtask

  function automatic uop_word_t random_uop();
    uop_word_t u;
    int        k;
    u.mode = 4'($urandom_range(0, 8));
    if ($urandom_range(0, 19) == 0) u.mode = 4'($urandom_range(0, 15));
    u.f3 = 3'($urandom);
    k = $urandom_range(0, 9);
    u.f7 = (k < 4) ? F7_BASE : (k < 7) ? F7_ALT : (k < 9) ? F7_MULDIV : 7'($urandom);
    u.imm = $urandom;
    if ($urandom_range(0, 1)) u.imm = $urandom_range(0, 4095) - 2048;
    u.a = $urandom;
    u.b = $urandom;
    k = $urandom_range(0, 7);
    if (k == 0) u.b = '0;
    if (k == 1) u.b = ALL_ONES;
    if (k == 2) u.a = 32'h8000_0000;
    if (k == 3) u.b = u.a;
    if (k == 4) u.b = $urandom_range(1, 17);
    u.pc = {$urandom} & ~32'd3;
    u.tag = 6'($urandom);
    u.rd = 5'($urandom);
    u.guess = '0;
    // Some right predictions and some wrong, so that both outcomes of redirect appear.
    k = $urandom_range(0, 2);
    if (k == 0) u.guess = u.pc + PC_STEP;
    else if (k == 1) u.guess = execute_uop(u).redirect_pc;
    else u.guess = $urandom;
    if (k == 1 && u.guess == '0) u.guess = u.pc + u.imm;
    return u;
  endfunction

  // Driver: presents the next word and holds it until busy is low at an edge.
  always @(posedge clk) begin
    uop_word_t u;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(execute_uop(pending_uops.pop_front()));
      end
      if ((start && busy) ||
          (pending_uops.size() > 0 && $urandom_range(0, 99) >= idle_pct)) begin
        u = pending_uops[0];
        start         <= 1'b1;
        in_mode       <= u.mode;
        in_funct3     <= u.f3;
        in_funct7     <= u.f7;
        in_immediate  <= u.imm;
        in_source_a   <= u.a;
        in_source_b   <= u.b;
        in_inst_pc    <= u.pc;
        in_guessed_pc <= u.guess;
        in_rob_tag    <= u.tag;
        in_dest_reg   <= u.rd;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed word is checked against the oldest expectation.
  always @(posedge clk) begin
    res_t got;
    res_t exp_r;
    if (rst_n && out_valid) begin
      got = '{out_tag_out, out_dest_out, out_reg_write, out_result_value, out_mem_kind,
              out_mem_address, out_store_data, out_redirect_valid, out_redirect_pc,
              out_error_code};
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected, got %p", $time, got);
        n_errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (got !== exp_r) begin
          $display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
          n_errors++;
        end
      end
    end
  end

  // Stimulus and the end of the run.
  initial begin
    uop_word_t u;
    int        phase;
    n_errors = 0;
    idle_pct = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_mode = '0;
    in_funct3 = '0;
    in_funct7 = '0;
    in_immediate = '0;
    in_source_a = '0;
    in_source_b = '0;
    in_inst_pc = '0;
    in_guessed_pc = '0;
    in_rob_tag = '0;
    in_dest_reg = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words: every class, the divide corners, errors and extremes.
    u = '{MODE_LUI, 0, 0, 32'h8000_0000, 0, 0, 32'hffff_fffc, 0, 63, 31};
    push_uop(u);
    u = '{MODE_AUIPC, 7, 127, 32'hffff_ffff, ALL_ONES, ALL_ONES, 32'h100, 0, 0, 0};
    push_uop(u);
    u = '{MODE_JAL, 0, 0, 32'h40, 0, 0, 32'h1000, 32'h1040, 5, 1};
    push_uop(u);
    u = '{MODE_JAL, 0, 0, 32'h40, 0, 0, 32'h1000, 32'h1044, 6, 2};
    push_uop(u);
    u = '{MODE_JALR, 0, 0, 32'h3, 32'h2000, 0, 0, 32'h2002, 7, 3};
    push_uop(u);
    u = '{MODE_JALR, 0, 0, 32'h3, 32'h2000, 0, 0, 32'h0, 8, 4};
    push_uop(u);
    u = '{MODE_BRANCH, BR_LT, 0, 32'h80, 32'h8000_0000, 1, 32'h500, 32'h504, 9, 0};
    push_uop(u);
    u = '{MODE_BRANCH, 3'd2, 0, 32'h80, 1, 1, 32'h500, 32'h0, 10, 5};
    push_uop(u);
    u = '{MODE_BRANCH, 3'd3, 0, 32'h80, 1, 2, 32'h500, 32'h504, 11, 6};
    push_uop(u);
    u = '{MODE_LOAD, 2, 0, 32'hffff_fff0, 32'h100, 32'h55, 0, 0, 12, 7};
    push_uop(u);
    u = '{MODE_STORE, 2, 0, 32'h10, 32'h100, 32'hdead_beef, 0, 0, 13, 8};
    push_uop(u);
    u = '{MODE_OPIMM, ALU_SR, F7_ALT, 32'd31, 32'h8000_0000, 0, 0, 0, 14, 9};
    push_uop(u);
    u = '{MODE_OPIMM, ALU_SLL, 0, 32'd31, ALL_ONES, 0, 0, 0, 15, 10};
    push_uop(u);
    u = '{MODE_OP, ALU_XOR, F7_MULDIV, 0, 32'h1234, 0, 0, 0, 16, 11};
    push_uop(u);
    u = '{MODE_OP, ALU_XOR, F7_MULDIV, 0, 32'h8000_0000, ALL_ONES, 0, 0, 17, 12};
    push_uop(u);
    u = '{MODE_OP, ALU_XOR, F7_MULDIV, 0, 32'hffff_fff9, 2, 0, 0, 18, 13};
    push_uop(u);
    u = '{MODE_OP, ALU_ADD, F7_MULDIV, 0, ALL_ONES, ALL_ONES, 0, 0, 19, 14};
    push_uop(u);
    u = '{MODE_OP, ALU_ADD, 7'h05, 0, 1, 2, 0, 0, 20, 15};
    push_uop(u);
    u = '{MODE_OP, ALU_OR, F7_MULDIV, 0, 1, 2, 0, 0, 21, 16};
    push_uop(u);
    u = '{MODE_OP, ALU_XOR, 7'h7f, 0, 32'hf0f0, 32'h0ff0, 0, 0, 22, 17};
    push_uop(u);
    u = '{4'd15, 0, 0, 0, 0, 0, 0, 0, 23, 18};
    push_uop(u);
    u = '{MODE_OP, ALU_SR, F7_ALT, 0, 32'h8000_0000, 32'h3f, 0, 0, 24, 19};
    push_uop(u);

    // Random words in several idling phases.
    for (phase = 0; phase < 4; phase++) begin
      wait (pending_uops.size() == 0);
      idle_pct = (phase == 1 || phase == 3) ? 58 : (phase == 2 ? 8 : 0);
      repeat (110) push_uop(random_uop());
    end
    wait (pending_uops.size() == 0 && !start);
    wait (expected_results.size() == 0);
    repeat (40) @(posedge clk);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
